/* src/iog_pkg.sv */
// Shared types and constants for the interrupt ownership guard.
// No dependencies.
`timescale 1ns / 1ps
package iog_pkg;
	localparam int IRQ_COUNT = 32;
	localparam int BOX_COUNT = 8;
	localparam int IRQ_W = 5;
	localparam logic [31:0] COUNTER_LIMIT = 32'hFFFF_FFFE;

	localparam logic [3:0] OP_CLAIM    = 4'd0;
	localparam logic [3:0] OP_SET_HDL  = 4'd1;
	localparam logic [3:0] OP_GET_HDL  = 4'd2;
	localparam logic [3:0] OP_ENABLE   = 4'd3;
	localparam logic [3:0] OP_DISABLE  = 4'd4;
	localparam logic [3:0] OP_DIS_ALL  = 4'd5;
	localparam logic [3:0] OP_EN_ALL   = 4'd6;
	localparam logic [3:0] OP_CLR_PEND = 4'd7;
	localparam logic [3:0] OP_SET_PEND = 4'd8;
	localparam logic [3:0] OP_GET_PEND = 4'd9;
	localparam logic [3:0] OP_SET_PRIO = 4'd10;
	localparam logic [3:0] OP_GET_PRIO = 4'd11;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_RANGE    = 3'd1;
	localparam logic [2:0] ST_RESERVED = 3'd2;
	localparam logic [2:0] ST_OWNED    = 3'd3;
	localparam logic [2:0] ST_UNREG    = 3'd4;
	localparam logic [2:0] ST_PRIO     = 3'd5;
	localparam logic [2:0] ST_OVERFLOW = 3'd6;

	localparam logic [1:0] REG_RESERVED = 2'd0;
	localparam logic [1:0] REG_BASE     = 2'd1;
	localparam logic [1:0] REG_MAXPRIO  = 2'd2;

	// classified request handed from front to back
	typedef struct packed {
		logic [3:0]  mode;
		logic        bad;        // range or reservation failure
		logic [2:0]  bad_status;
		logic [IRQ_W-1:0] line;
		logic [2:0]  box;
		logic [2:0]  cbox;
		logic [31:0] hword;
		logic [7:0]  prio;
		logic        prio_high;  // above max virtual priority
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] read_value;
		logic [31:0] enable_mask;
	} rsp_t;
endpackage

/* src/interrupt_ownership_guard_top.sv */
// Top level of the interrupt ownership guard: APB registers, front and back.
// Depends on iog_pkg, iog_front, iog_back.
//
//  channel | signals                                  | direction
//  in      | in_valid/in_ready, mode..priority_value  | request in
//  out     | out_valid/out_ready, status..enable_mask | result out
//  cfg     | psel/penable/pwrite/paddr/pwdata/prdata  | APB registers
//
// The front registers a checked request into a two-entry queue; the back
// executes it against the tables and registers the result, so a request passes
// the queue and the result register; one is taken per cycle unless out_ready stalls.
// Reset clears all tables and counters at once; no clearing pass.
// Either side stalls independently through the queue and the result register.
`timescale 1ns / 1ps
module interrupt_ownership_guard_top import iog_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  mode,
	input  logic [8:0]  irq_number,
	input  logic [2:0]  active_box,
	input  logic [2:0]  claim_box,
	input  logic [31:0] handler_word,
	input  logic [7:0]  priority_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [31:0] read_value,
	output logic [31:0] enable_mask,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [31:0] resv_q;
	logic [7:0]  base_q, maxp_q;
	logic        q_valid, q_ready;
	req_t        q_req;
	rsp_t        rsp;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resv_q <= '0;
			base_q <= 8'd1;
			maxp_q <= 8'd254;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_RESERVED: resv_q <= pwdata;
				REG_BASE:     base_q <= pwdata[7:0];
				REG_MAXPRIO:  maxp_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_RESERVED: prdata = resv_q;
			REG_BASE:     prdata = {24'd0, base_q};
			REG_MAXPRIO:  prdata = {24'd0, maxp_q};
			default:      prdata = '0;
		endcase
	end

	iog_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .mode, .irq_number, .active_box,
		.claim_box, .handler_word, .priority_value,
		.reserved_mask(resv_q), .max_virtual_priority(maxp_q),
		.q_valid, .q_ready, .q_req
	);

	iog_back u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_req, .base_priority(base_q),
		.out_valid, .out_ready, .rsp
	);

	assign status = rsp.status;
	assign read_value = rsp.read_value;
	assign enable_mask = rsp.enable_mask;

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_OVERFLOW) else $error("bad status");
	a_err_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> read_value == '0) else $error("read on error");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(enable_mask))
		else $error("result dropped");
endmodule

/* src/iog_front.sv */
// Front end: accepts requests, does range, reservation and priority-limit checks.
// Depends on iog_pkg.
`timescale 1ns / 1ps
module iog_front import iog_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  mode,
	input  logic [8:0]  irq_number,
	input  logic [2:0]  active_box,
	input  logic [2:0]  claim_box,
	input  logic [31:0] handler_word,
	input  logic [7:0]  priority_value,
	input  logic [31:0] reserved_mask,
	input  logic [7:0]  max_virtual_priority,
	output logic        q_valid,
	input  logic        q_ready,
	output req_t        q_req
);
	// two-entry queue
	req_t       fifo_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	req_t       req;
	logic       push, pop;

	always_comb begin
		req = '0;
		req.mode = mode;
		req.line = irq_number[IRQ_W-1:0];
		req.box = active_box;
		req.cbox = claim_box;
		req.hword = handler_word;
		req.prio = priority_value;
		req.prio_high = priority_value > max_virtual_priority;
		if (irq_number >= 9'(IRQ_COUNT)) begin
			req.bad = 1'b1;
			req.bad_status = ST_RANGE;
		end else if (reserved_mask[irq_number[IRQ_W-1:0]]) begin
			req.bad = 1'b1;
			req.bad_status = ST_RESERVED;
		end
	end

	assign in_ready = cnt_q != 2'd2;
	assign push = in_valid && in_ready;
	assign q_valid = cnt_q != 2'd0;
	assign pop = q_valid && q_ready;
	assign q_req = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

/* src/iog_back.sv */
// Back end: per-line tables, nest counters and request execution.
// Depends on iog_pkg.
`timescale 1ns / 1ps
module iog_back import iog_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_ready,
	input  req_t        q_req,
	input  logic [7:0]  base_priority,
	output logic        out_valid,
	input  logic        out_ready,
	output rsp_t        rsp
);
	logic [2:0]  owner_q [IRQ_COUNT];
	logic [31:0] handler_q [IRQ_COUNT];
	logic [7:0]  prio_q [IRQ_COUNT];
	logic [31:0] cnt_q [BOX_COUNT];
	logic [IRQ_COUNT-1:0] en_q, pend_q, saved_q;
	logic        ov_q;
	rsp_t        rsp_q;

	logic [2:0]  st;
	logic [31:0] rd;
	logic [IRQ_COUNT-1:0] en_n, pend_n, saved_n, own_m, b;
	logic        owner_w, handler_w, prio_w, cnt_w;
	logic [2:0]  owner_d;
	logic [7:0]  prio_d;
	logic [31:0] cnt_d, cnt_cur;
	logic        reg_l, other, box_ok;
	logic        take;

	assign q_ready = !ov_q || out_ready;
	assign take = q_valid && q_ready;

	always_comb begin
		for (int i = 0; i < IRQ_COUNT; i++)
			own_m[i] = owner_q[i] == q_req.box;
	end

	always_comb begin
		st = ST_OK; rd = '0;
		en_n = en_q; pend_n = pend_q; saved_n = saved_q;
		owner_w = 1'b0; handler_w = 1'b0; prio_w = 1'b0; cnt_w = 1'b0;
		owner_d = q_req.box; prio_d = base_priority;
		box_ok = 32'(q_req.box) < BOX_COUNT;
		cnt_cur = box_ok ? cnt_q[q_req.box] : '0;
		cnt_d = cnt_cur;
		b = IRQ_COUNT'(1) << q_req.line;
		reg_l = handler_q[q_req.line] != '0;
		other = owner_q[q_req.line] != q_req.box &&
			(owner_q[q_req.line] != '0 || reg_l);
		if (q_req.mode == OP_CLAIM) begin
			if (q_req.bad) st = q_req.bad_status;
			else if (owner_q[q_req.line] != '0 || reg_l) st = ST_OWNED;
			else begin
				owner_w = 1'b1; owner_d = q_req.cbox; handler_w = 1'b1;
			end
		end else if (q_req.mode == OP_DIS_ALL) begin
			if (box_ok) begin
				if (cnt_cur == '0) begin
					saved_n = own_m & en_q;
					en_n = en_q & ~(own_m & en_q);
				end
				if (cnt_cur < COUNTER_LIMIT) begin
					cnt_w = 1'b1; cnt_d = cnt_cur + 32'd1;
				end else st = ST_OVERFLOW;
			end
		end else if (q_req.mode == OP_EN_ALL) begin
			if (box_ok) begin
				if (cnt_cur == 32'd1) begin
					en_n = en_q | (own_m & saved_q);
					saved_n = saved_q & ~(own_m & saved_q);
				end
				if (cnt_cur != '0) begin
					cnt_w = 1'b1; cnt_d = cnt_cur - 32'd1;
				end
			end
		end else if (q_req.mode <= OP_GET_PRIO) begin
			if (q_req.bad) st = q_req.bad_status;
			else if (other) st = ST_OWNED;
			else begin
				unique case (q_req.mode)
					OP_SET_HDL: begin
						owner_w = 1'b1; handler_w = 1'b1; prio_w = 1'b1;
						if (q_req.hword == '0) begin
							owner_d = '0;
							en_n = en_q & ~b;
						end
					end
					OP_GET_HDL: rd = handler_q[q_req.line];
					OP_ENABLE: begin
						if (reg_l) begin
							if (cnt_cur == '0) en_n = en_q | b;
							else saved_n = saved_q | b;
						end else if (!en_q[q_req.line]) st = ST_UNREG;
					end
					OP_DISABLE: begin
						if (reg_l) en_n = en_q & ~b;
						else if (en_q[q_req.line]) st = ST_UNREG;
					end
					OP_CLR_PEND: begin
						if (reg_l) pend_n = pend_q & ~b;
						else st = ST_UNREG;
					end
					OP_SET_PEND: begin
						if (reg_l) pend_n = pend_q | b;
						else st = ST_UNREG;
					end
					OP_GET_PEND: rd = 32'(pend_q[q_req.line]);
					OP_SET_PRIO: begin
						if (q_req.prio_high) st = ST_PRIO;
						else if (!reg_l) st = ST_UNREG;
						else begin
							prio_w = 1'b1; prio_d = base_priority + q_req.prio;
						end
					end
					default: rd = 32'(prio_q[q_req.line]) - 32'(base_priority);
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q.status <= st;
			rsp_q.read_value <= (st == ST_OK) ? rd : '0;
			rsp_q.enable_mask <= en_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < IRQ_COUNT; i++) begin
				owner_q[i] <= '0; handler_q[i] <= '0; prio_q[i] <= '0;
			end
			for (int k = 0; k < BOX_COUNT; k++) cnt_q[k] <= '0;
			en_q <= '0; pend_q <= '0; saved_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (take) begin
				if (owner_w) owner_q[q_req.line] <= owner_d;
				if (handler_w) handler_q[q_req.line] <= q_req.hword;
				if (prio_w) prio_q[q_req.line] <= prio_d;
				en_q <= en_n; pend_q <= pend_n; saved_q <= saved_n;
				if (cnt_w) cnt_q[q_req.box] <= cnt_d;
				ov_q <= 1'b1;
			end else if (out_ready) ov_q <= 1'b0;
		end
	end

	assign out_valid = ov_q;
	assign rsp = rsp_q;
endmodule

/* test/iog_checker.sv */
// Checker for the interrupt ownership guard: watches request and result channels,
// predicts each result from its own copy of the guard state and compares fields.
// Depends on iog_pkg.
`timescale 1ns / 1ps
module iog_checker import iog_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [3:0]  mode,
	input  logic [8:0]  irq_number,
	input  logic [2:0]  active_box,
	input  logic [2:0]  claim_box,
	input  logic [31:0] handler_word,
	input  logic [7:0]  priority_value,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  status,
	input  logic [31:0] read_value,
	input  logic [31:0] enable_mask,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output int          fail_count,
	output int          pending_results,
	output int          result_count
);
	logic [31:0] g_reserved;
	logic [7:0]  g_base;
	logic [7:0]  g_maxprio;
	logic [2:0]  g_owner [IRQ_COUNT];
	logic [31:0] g_handler [IRQ_COUNT];
	logic [7:0]  g_prio [IRQ_COUNT];
	logic [31:0] g_enable, g_pend, g_saved;
	logic [31:0] g_nest [BOX_COUNT];
	rsp_t expected_q[$];

	assign pending_results = expected_q.size();

	function automatic logic [2:0] line_check(logic [8:0] line);
		if (line >= IRQ_COUNT) return ST_RANGE;
		if (g_reserved[line[4:0]]) return ST_RESERVED;
		return ST_OK;
	endfunction

	task automatic predict_guard(input logic [3:0] m, input logic [8:0] line,
			input logic [2:0] box, input logic [2:0] cbox, input logic [31:0] hw,
			input logic [7:0] pv);
		logic [2:0]  st;
		logic [31:0] rd;
		logic [4:0]  l;
		logic        is_reg;
		rsp_t        r;
		st = ST_OK;
		rd = '0;
		l = line[4:0];
		if (m == OP_CLAIM) begin
			st = line_check(line);
			if (st == ST_OK) begin
				if (g_owner[l] != 0 || g_handler[l] != 0) st = ST_OWNED;
				else begin
					g_owner[l] = cbox;
					g_handler[l] = hw;
				end
			end
		end else if (m == OP_DIS_ALL) begin
			if (g_nest[box] == 0)
				for (int i = 0; i < IRQ_COUNT; i++)
					if (g_owner[i] == box && g_enable[i]) begin
						g_saved[i] = 1'b1;
						g_enable[i] = 1'b0;
					end else g_saved[i] = 1'b0;
			if (g_nest[box] < COUNTER_LIMIT) g_nest[box]++;
			else st = ST_OVERFLOW;
		end else if (m == OP_EN_ALL) begin
			if (g_nest[box] == 1)
				for (int i = 0; i < IRQ_COUNT; i++)
					if (g_owner[i] == box && g_saved[i]) begin
						g_enable[i] = 1'b1;
						g_saved[i] = 1'b0;
					end
			if (g_nest[box] > 0) g_nest[box]--;
		end else if (m <= OP_GET_PRIO) begin
			st = line_check(line);
			if (st == ST_OK && g_owner[l] != box && (g_owner[l] != 0 || g_handler[l] != 0))
				st = ST_OWNED;
			if (st == ST_OK) begin
				is_reg = g_handler[l] != 0;
				case (m)
					OP_SET_HDL: begin
						if (hw != 0) g_owner[l] = box;
						else begin
							g_enable[l] = 1'b0;
							g_owner[l] = 0;
						end
						g_handler[l] = hw;
						g_prio[l] = g_base;
					end
					OP_GET_HDL: rd = g_handler[l];
					OP_ENABLE: begin
						if (is_reg) begin
							if (g_nest[box] == 0) g_enable[l] = 1'b1;
							else g_saved[l] = 1'b1;
						end else if (!g_enable[l]) st = ST_UNREG;
					end
					OP_DISABLE: begin
						if (is_reg) g_enable[l] = 1'b0;
						else if (g_enable[l]) st = ST_UNREG;
					end
					OP_CLR_PEND: if (is_reg) g_pend[l] = 1'b0; else st = ST_UNREG;
					OP_SET_PEND: if (is_reg) g_pend[l] = 1'b1; else st = ST_UNREG;
					OP_GET_PEND: rd = {31'd0, g_pend[l]};
					OP_SET_PRIO: begin
						if (pv > g_maxprio) st = ST_PRIO;
						else if (!is_reg) st = ST_UNREG;
						else g_prio[l] = g_base + pv;
					end
					default: rd = {24'd0, g_prio[l]} - {24'd0, g_base};
				endcase
			end
		end
		r.status = st;
		r.read_value = (st == ST_OK) ? rd : '0;
		r.enable_mask = g_enable;
		expected_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		int   errs;
		errs = 0;
		if (!arst_n) begin
			g_reserved <= '0;
			g_base <= 8'd1;
			g_maxprio <= 8'd254;
			g_enable <= '0;
			g_pend <= '0;
			g_saved <= '0;
			for (int i = 0; i < IRQ_COUNT; i++) begin
				g_owner[i] <= '0;
				g_handler[i] <= '0;
				g_prio[i] <= '0;
			end
			for (int i = 0; i < BOX_COUNT; i++) g_nest[i] <= '0;
			expected_q.delete();
			fail_count <= 0;
			result_count <= 0;
		end else begin
			// result check first: a request accepted this edge cannot produce it yet
			if (out_valid && out_ready) begin
				result_count <= result_count + 1;
				if (expected_q.size() == 0) begin
					$error("unexpected result: status %0d", status);
					errs++;
				end else begin
					e = expected_q.pop_front();
					if (e.status !== status) begin
						$error("status: expected %0d got %0d", e.status, status);
						errs++;
					end
					if (e.read_value !== read_value) begin
						$error("read_value: expected %h got %h", e.read_value, read_value);
						errs++;
					end
					if (e.enable_mask !== enable_mask) begin
						$error("enable_mask: expected %h got %h", e.enable_mask, enable_mask);
						errs++;
					end
				end
				fail_count <= fail_count + errs;
			end
			if (in_valid && in_ready)
				predict_guard(mode, irq_number, active_box, claim_box, handler_word,
					priority_value);
			if (psel && penable && pwrite && pready)
				case (paddr[3:2])
					REG_RESERVED: g_reserved = pwdata;
					REG_BASE:     g_base = pwdata[7:0];
					REG_MAXPRIO:  g_maxprio = pwdata[7:0];
					default: ;
				endcase
		end
	end
endmodule

/* test/tb_interrupt_ownership_guard_top.sv */
// Testbench top for the interrupt ownership guard: clock, reset, APB setup,
// directed and random requests, idling phases and the verdict.
// Depends on iog_pkg, interrupt_ownership_guard_top, iog_checker.
`timescale 1ns / 1ps
module tb_interrupt_ownership_guard_top import iog_pkg::*; ();
	logic        clk, arst_n;
	logic        in_valid, in_ready, out_valid, out_ready;
	logic [3:0]  mode;
	logic [8:0]  irq_number;
	logic [2:0]  active_box, claim_box;
	logic [31:0] handler_word;
	logic [7:0]  priority_value;
	logic [2:0]  status;
	logic [31:0] read_value, enable_mask;
	logic        psel, penable, pwrite, pready;
	logic [3:0]  paddr;
	logic [31:0] pwdata, prdata;
	int fail_count, pending_results, result_count;
	int send_idle_pct, recv_stall_pct, hold_off;
	int cycle_count;

	interrupt_ownership_guard_top dut (.*);
	iog_checker chk (.*);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("interrupt_ownership_guard_top test failed");
			$finish;
		end
	end

	// result side: random stalls, plus a long hold-off when asked
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (pending_results != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_request(input logic [3:0] m, input logic [8:0] line,
			input logic [2:0] box, input logic [2:0] cbox, input logic [31:0] hw,
			input logic [7:0] pv);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m; irq_number <= line; active_box <= box;
		claim_box <= cbox; handler_word <= hw; priority_value <= pv;
		// in_ready only moves at rising edges, so it is stable here
		while (!in_ready) @(negedge clk);
		@(posedge clk);
		@(negedge clk);
	endtask

	// mostly legal lines owned by a few boxes, with some noise
	task automatic random_request;
		logic [3:0]  m;
		logic [8:0]  line;
		logic [31:0] hw;
		m = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(11));
		line = ($urandom_range(15) == 0) ? 9'($urandom) : 9'($urandom_range(31));
		hw = ($urandom_range(5) == 0) ? 32'd0 : $urandom;
		send_request(m, line, 3'($urandom_range(3)), 3'($urandom_range(3)), hw,
			($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(20)));
	endtask

	initial begin
		cycle_count = 0; hold_off = 0;
		send_idle_pct = 0; recv_stall_pct = 0;
		arst_n = 1'b0; in_valid = 1'b0; out_ready = 1'b0;
		mode = '0; irq_number = '0; active_box = '0; claim_box = '0;
		handler_word = '0; priority_value = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		reg_write(REG_RESERVED, 32'h8000_0001);
		reg_write(REG_BASE, 32'd0);
		reg_write(REG_MAXPRIO, 32'd255);

		// directed: range, reserved, claim, ownership, each operation
		send_request(OP_CLAIM, 9'd511, 3'd1, 3'd1, 32'hFFFF_FFFF, 8'd0);
		send_request(OP_CLAIM, 9'd0, 3'd1, 3'd1, 32'h1, 8'd0);
		send_request(OP_CLAIM, 9'd31, 3'd1, 3'd1, 32'h1, 8'd0);
		send_request(OP_CLAIM, 9'd5, 3'd0, 3'd7, 32'hFFFF_FFFF, 8'd0);
		send_request(OP_CLAIM, 9'd5, 3'd1, 3'd1, 32'h1234, 8'd0);
		send_request(OP_ENABLE, 9'd6, 3'd2, 3'd0, 32'd0, 8'd0);
		send_request(OP_SET_HDL, 9'd6, 3'd2, 3'd0, 32'hAAAA_5555, 8'd0);
		send_request(OP_ENABLE, 9'd6, 3'd2, 3'd0, 32'd0, 8'd0);
		send_request(OP_GET_HDL, 9'd6, 3'd2, 3'd0, 32'd0, 8'd0);
		send_request(OP_GET_HDL, 9'd6, 3'd3, 3'd0, 32'd0, 8'd0);
		send_request(OP_SET_PEND, 9'd6, 3'd2, 3'd0, 32'd0, 8'd0);
		send_request(OP_GET_PEND, 9'd6, 3'd2, 3'd0, 32'd0, 8'd0);
		send_request(OP_CLR_PEND, 9'd6, 3'd2, 3'd0, 32'd0, 8'd0);
		send_request(OP_SET_PRIO, 9'd6, 3'd2, 3'd0, 32'd0, 8'd255);
		send_request(OP_GET_PRIO, 9'd6, 3'd2, 3'd0, 32'd0, 8'd0);
		send_request(OP_DIS_ALL, 9'd0, 3'd2, 3'd0, 32'd0, 8'd0);
		send_request(OP_DIS_ALL, 9'd0, 3'd2, 3'd0, 32'd0, 8'd0);
		send_request(OP_ENABLE, 9'd6, 3'd2, 3'd0, 32'd0, 8'd0);
		send_request(OP_EN_ALL, 9'd0, 3'd2, 3'd0, 32'd0, 8'd0);
		send_request(OP_EN_ALL, 9'd0, 3'd2, 3'd0, 32'd0, 8'd0);
		send_request(OP_DISABLE, 9'd6, 3'd2, 3'd0, 32'd0, 8'd0);
		send_request(OP_SET_HDL, 9'd6, 3'd2, 3'd0, 32'd0, 8'd0);
		send_request(OP_DISABLE, 9'd7, 3'd2, 3'd0, 32'd0, 8'd0);
		send_request(4'd15, 9'd3, 3'd7, 3'd0, 32'd0, 8'd0);
		drain();

		// random phases, each under a new register setting
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
				default: begin send_idle_pct = 32; recv_stall_pct = 32; end
			endcase
			reg_write(REG_RESERVED, (ph == 7) ? 32'hFFFF_FFFF :
				(ph == 0) ? 32'd0 : ($urandom & $urandom));
			reg_write(REG_BASE, (ph == 3) ? 32'd255 : 32'($urandom_range(255)));
			reg_write(REG_MAXPRIO, (ph == 5) ? 32'd0 : 32'($urandom_range(255)));
			if (ph == 2) hold_off = 60;
			for (int n = 0; n < 160; n++) random_request();
			drain();
		end
		$display("covered: directed checks of every mode plus 1280 random requests");
		$display("over 8 register settings with idle, stall and hold-off phases");
		if (fail_count == 0)
			$display("interrupt_ownership_guard_top test passed");
		else
			$display("interrupt_ownership_guard_top test failed");
		$finish;
	end
endmodule
